// ===== design/fn_pkg.sv =====
// Shared types and constants for the fraction normalizer.
// No dependencies; imported by every module of the block.
package fn_pkg;

	// Width of the signed input parts; the reduced parts are one bit narrower.
	localparam int WIDTH = 16;
	localparam int MAG_W = WIDTH - 1;
	localparam int CNT_W = $clog2(MAG_W);

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_GCD  = 5'b00010,
		S_DIVN = 5'b00100,
		S_DIVD = 5'b01000,
		S_DONE = 5'b10000
	} fn_state_t;

	// Reduced fraction handed from the core to the output stage.
	typedef struct packed {
		logic [MAG_W-1:0] numer;
		logic [MAG_W-1:0] denom;
	} fn_res_t;

	// Core status seen by the top level.
	typedef struct packed {
		logic idle;
		logic done;
	} fn_status_t;

endpackage

// ===== design/fn_alu.sv =====
// Shared compare-and-subtract unit of the fraction normalizer.
// Depends on fn_pkg for the operand width.
module fn_alu import fn_pkg::*; (
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	output logic             ge,
	output logic [WIDTH-1:0] dif
);

	// Compare, then subtract the smaller operand from the larger one.
	always_comb begin
		ge  = (x >= y);
		dif = ge ? (x - y) : (y - x);
	end

endmodule

// ===== design/fn_core.sv =====
// Sequencer and datapath: binary GCD, then two restoring divisions by the GCD.
// Depends on fn_pkg and on the shared unit fn_alu.
module fn_core import fn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WIDTH-1:0]   numer,
	input  logic [WIDTH-1:0]   denom,
	input  logic               take,
	output fn_status_t         status,
	output fn_res_t            res
);

	fn_state_t         state_q;
	logic [MAG_W-1:0]  a_q, b_q, g_q, n_q, d_q, rem_q, quo_q, resn_q;
	logic [CNT_W-1:0]  k_q, cnt_q;

	logic [WIDTH-1:0]  alu_x, alu_y, alu_dif, rem_sh;
	logic              alu_ge;
	logic              in_ok, gcd_done, cnt_last;

	assign in_ok    = !numer[WIDTH-1] && !denom[WIDTH-1] && (denom[MAG_W-1:0] != '0);
	assign gcd_done = (a_q == '0) || (b_q == '0);
	assign cnt_last = (cnt_q == CNT_W'(MAG_W - 1));
	assign rem_sh   = {rem_q, quo_q[MAG_W-1]};

	// Steer the shared unit: GCD operands or partial remainder against divisor.
	always_comb begin
		if (state_q == S_GCD) begin
			alu_x = {1'b0, a_q};
			alu_y = {1'b0, b_q};
		end else begin
			alu_x = rem_sh;
			alu_y = {1'b0, g_q};
		end
	end

	fn_alu u_alu (
		.x   (alu_x),
		.y   (alu_y),
		.ge  (alu_ge),
		.dif (alu_dif)
	);

	// Advance the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (in_ok && numer[MAG_W-1:0] != '0) state_q <= S_GCD;
						else                                 state_q <= S_DONE;
					end
				end
				S_GCD:  if (gcd_done) state_q <= S_DIVN;
				S_DIVN: if (cnt_last) state_q <= S_DIVD;
				S_DIVD: if (cnt_last) state_q <= S_DONE;
				S_DONE: if (take)     state_q <= S_IDLE;
				default:              state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				n_q   <= numer[MAG_W-1:0];
				d_q   <= denom[MAG_W-1:0];
				a_q   <= numer[MAG_W-1:0];
				b_q   <= denom[MAG_W-1:0];
				k_q   <= '0;
				resn_q <= '0;
				// Invalid input gives 0/0, zero numerator keeps the denominator.
				quo_q <= in_ok ? denom[MAG_W-1:0] : '0;
			end
			S_GCD: begin
				if (gcd_done) begin
					g_q   <= (a_q | b_q) << k_q;
					rem_q <= '0;
					quo_q <= n_q;
					cnt_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (alu_ge) begin
					a_q <= alu_dif[MAG_W:1];
				end else begin
					b_q <= alu_dif[MAG_W:1];
				end
			end
			S_DIVN, S_DIVD: begin
				cnt_q <= cnt_q + 1'b1;
				rem_q <= alu_ge ? alu_dif[MAG_W-1:0] : rem_sh[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], alu_ge};
				// Hand the numerator quotient over and start on the denominator.
				if (cnt_last && state_q == S_DIVN) begin
					resn_q <= {quo_q[MAG_W-2:0], alu_ge};
					rem_q  <= '0;
					quo_q  <= d_q;
					cnt_q  <= '0;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign status.idle = (state_q == S_IDLE);
	assign status.done = (state_q == S_DONE);
	assign res.numer   = resn_q;
	assign res.denom   = quo_q;

endmodule

// ===== design/fraction_normalizer.sv =====
// Fraction normalizer: reduces a signed numerator/denominator pair to lowest
// terms. One item is taken at a time; in_ready stays low from acceptance until
// the result moves into the output register. An invalid input or a zero
// numerator skips the binary GCD loop and the two bit-serial divisions, which
// otherwise share a single compare-subtract unit. The output register lets the
// next item start while a result waits.
// Depends on fn_pkg, fn_core and fn_alu.
module fraction_normalizer import fn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WIDTH-1:0]  numer_in,
	input  logic [WIDTH-1:0]  denom_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MAG_W-1:0]  numer_out,
	output logic [MAG_W-1:0]  denom_out,
	output logic              is_empty
);

	fn_status_t        status;
	fn_res_t           res;
	logic              take;
	logic              out_valid_q;
	logic [MAG_W-1:0]  numer_q, denom_q;
	logic              empty_q;

	assign in_ready = status.idle;
	assign take     = status.done && (!out_valid_q || out_ready);

	fn_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid),
		.numer  (numer_in),
		.denom  (denom_in),
		.take   (take),
		.status (status),
		.res    (res)
	);

	// Output beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result beat.
	always_ff @(posedge clk) begin
		if (take) begin
			numer_q <= res.numer;
			denom_q <= res.denom;
			empty_q <= (res.numer == '0) || (res.denom == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign numer_out = numer_q;
	assign denom_out = denom_q;
	assign is_empty  = empty_q;

endmodule

// ===== design/fn_checker.sv =====
// Port-level checks for the fraction normalizer, bound to the top level.
// Depends on fn_pkg for the field widths.
module fn_checker import fn_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [WIDTH-1:0]  numer_in,
	input logic [WIDTH-1:0]  denom_in,
	input logic              out_valid,
	input logic              out_ready,
	input logic [MAG_W-1:0]  numer_out,
	input logic [MAG_W-1:0]  denom_out,
	input logic              is_empty
);

	// Hold a stalled result beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(numer_out) && $stable(denom_out))
		else $error("stalled result beat changed");

	// Flag empty exactly when a part is zero.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_empty == (numer_out == '0 || denom_out == '0))
		else $error("is_empty disagrees with result parts");

	// Zero denominator only comes with zero numerator.
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && denom_out == '0 |-> numer_out == '0)
		else $error("zero denominator with nonzero numerator");

	// Drop ready after an input beat is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready after accepted input beat");

endmodule

bind fraction_normalizer fn_checker u_fn_checker (.*);

// ===== tb/sv/fraction_normalizer_test.sv =====
// Self-checking testbench for fraction_normalizer: drives signed fraction beats,
// reduces each one in a local GCD predictor and checks every result beat.
// Depends on fn_pkg and the fraction_normalizer RTL.
module fraction_normalizer_test;
	import fn_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 100;

	// Expected reduced fraction for one accepted beat
	typedef struct packed {
		logic [MAG_W-1:0] numer;
		logic [MAG_W-1:0] denom;
		logic             empty_flag;
	} fraction_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [WIDTH-1:0] numer_in = '0;
	logic [WIDTH-1:0] denom_in = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [MAG_W-1:0] numer_out;
	logic [MAG_W-1:0] denom_out;
	logic             is_empty;

	fraction_t   pending_fractions[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sink_wait = 0;
	logic        sink_gaps = 1'b1;
	logic        sink_blocked = 1'b0;
	bit          src_gaps = 1'b1;

	fraction_normalizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.numer_in  (numer_in),
		.denom_in  (denom_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.numer_out (numer_out),
		.denom_out (denom_out),
		.is_empty  (is_empty)
	);

	always #2 clk = ~clk;

	// Reduce n/d to lowest terms; negative numerator or non-positive denominator gives 0/0
	function automatic fraction_t reduce_fraction(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
		fraction_t   r;
		int unsigned a;
		int unsigned b;
		int unsigned t;
		r = '0;
		if (!n[WIDTH-1] && !d[WIDTH-1] && d != '0) begin
			a = 32'(n);
			b = 32'(d);
			if (n == '0) begin
				a = 1;
			end else begin
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
			end
			r.numer = MAG_W'(int'(n) / a);
			r.denom = MAG_W'(int'(d) / a);
		end
		r.empty_flag = (r.numer == '0) || (r.denom == '0);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// Offer one beat after a random gap when source gaps are on; hold it until accepted, then log its expectation
	task automatic send_fraction(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] d);
		int unsigned gap;
		gap = src_gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		numer_in <= n;
		denom_in <= d;
		do @(posedge clk); while (!in_ready);
		pending_fractions.push_back(reduce_fraction(n, d));
	endtask

	task automatic idle_source();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_fractions.size() != 0) @(posedge clk);
	endtask

	// Block the result side for the given number of cycles
	task automatic hold_sink(input int unsigned cycles);
		sink_blocked <= 1'b1;
		repeat (cycles) @(posedge clk);
		sink_blocked <= 1'b0;
	endtask

	// Draw one input part: mostly valid magnitudes, some raw 16-bit noise
	function automatic logic [WIDTH-1:0] draw_part(input int unsigned kind);
		case (kind)
			0: return WIDTH'($urandom);
			1: return WIDTH'($urandom_range(1, 64));
			2: return WIDTH'($urandom_range(32700, 32767));
			default: return WIDTH'($urandom_range(0, 32767));
		endcase
	endfunction

	// Build one random item covering invalid, zero, shared-factor and plain cases
	task automatic send_random_fraction();
		int unsigned      pick;
		int unsigned      factor;
		logic [WIDTH-1:0] n;
		logic [WIDTH-1:0] d;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			n = draw_part(0);
			d = draw_part(0);
		end else if (pick < 18) begin
			n = draw_part($urandom_range(0, 3));
			d = draw_part($urandom_range(0, 3));
			if ($urandom_range(0, 1))
				n[WIDTH-1] = 1'b1;
			else
				d = $urandom_range(0, 1) ? '0 : (d | WIDTH'(1 << (WIDTH - 1)));
		end else if (pick < 23) begin
			n = '0;
			d = WIDTH'($urandom_range(1, 32767));
		end else if (pick < 55) begin
			factor = $urandom_range(1, 255);
			n = WIDTH'(factor * $urandom_range(0, 32767 / factor));
			d = WIDTH'(factor * $urandom_range(1, 32767 / factor));
		end else if (pick < 80) begin
			n = draw_part($urandom_range(2, 3));
			d = WIDTH'($urandom_range(1, 32767));
		end else begin
			n = draw_part(1);
			d = draw_part(1);
		end
		send_fraction(n, d);
	endtask

	// Edge values, invalid forms and known reductions
	task automatic test_directed();
		send_fraction(16'h0000, 16'h0001);
		send_fraction(16'h0000, 16'h7FFF);
		send_fraction(16'h7FFF, 16'h7FFF);
		send_fraction(16'h7FFF, 16'h0001);
		send_fraction(16'h0001, 16'h7FFF);
		send_fraction(16'h7FFF, 16'h7FFE);
		send_fraction(16'd12, 16'd18);
		send_fraction(16'd30030, 16'd15015);
		send_fraction(16'd32749, 16'd32719);
		send_fraction(16'h4000, 16'h2000);
		send_fraction(16'h0001, 16'h0001);
		send_fraction(16'd28672, 16'd12288);
		send_fraction(16'hFFFF, 16'h0005);
		send_fraction(16'h8000, 16'h0005);
		send_fraction(16'h0005, 16'h0000);
		send_fraction(16'h0005, 16'hFFFF);
		send_fraction(16'h0005, 16'h8000);
		send_fraction(16'h0000, 16'h0000);
		send_fraction(16'h0000, 16'h8000);
		send_fraction(16'hFFFF, 16'hFFFF);
		send_fraction(16'h8000, 16'h8000);
		send_fraction(16'h7FFF, 16'h8000);
		idle_source();
		wait_drained();
	endtask

	// Random items with random idling on both sides and periodic full drains
	task automatic test_random_mix();
		for (int i = 0; i < 620; i++) begin
			send_random_fraction();
			if (i % 97 == 96) begin
				idle_source();
				wait_drained();
			end
		end
		idle_source();
		wait_drained();
	endtask

	// Back-to-back beats with no idling on either side
	task automatic test_back_to_back();
		src_gaps = 1'b0;
		sink_gaps <= 1'b0;
		for (int i = 0; i < 160; i++) begin
			send_random_fraction();
		end
		idle_source();
		wait_drained();
		sink_gaps <= 1'b1;
		src_gaps = 1'b1;
	endtask

	// Stall the result side long enough that the block backs up its input
	task automatic test_output_backpressure();
		src_gaps = 1'b0;
		fork
			hold_sink(400);
			begin
				for (int i = 0; i < 30; i++) begin
					send_random_fraction();
				end
			end
		join
		idle_source();
		wait_drained();
		src_gaps = 1'b1;
	endtask

	// Random stall per result beat, blocked outright during a hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait <= 0;
		end else begin : sink_step
			int unsigned wait_left;
			wait_left = sink_wait;
			if (out_valid && out_ready)
				wait_left = sink_gaps ? $urandom_range(0, 19) : 0;
			else if (wait_left > 0)
				wait_left = wait_left - 1;
			sink_wait <= wait_left;
			out_ready <= (wait_left == 0) && !sink_blocked;
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_beat
		fraction_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_fractions.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d with nothing expected",
					numer_out, denom_out));
			end else begin
				want = pending_fractions.pop_front();
				if (numer_out !== want.numer)
					report_mismatch($sformatf("numer_out %0d, expected %0d",
						numer_out, want.numer));
				if (denom_out !== want.denom)
					report_mismatch($sformatf("denom_out %0d, expected %0d",
						denom_out, want.denom));
				if (is_empty !== want.empty_flag)
					report_mismatch($sformatf("is_empty %b, expected %b",
						is_empty, want.empty_flag));
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_back_to_back();
		test_output_backpressure();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
